// ===== rtl/core/fat12_cluster_chain_step_macros.svh =====
// Assertion macros for the FAT12 cluster chain step block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef FAT12_CLUSTER_CHAIN_STEP_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_STEP_MACROS_SVH

`ifndef SYNTHESIS
`define FCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcc assertion failed");
`define FCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcc assertion failed");
`else
`define FCC_ASSERT_IMP(label, ante, cons)
`define FCC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/fcc_pkg.sv =====
// Shared constants and types for the FAT12 cluster chain step block.
// No dependencies.
package fcc_pkg;

  localparam int FCC_TABLE_BYTES = 8192;
  localparam int FCC_POS_W       = 18;

  localparam logic [11:0] ENTRY_END = 12'hFF8;
  localparam logic [11:0] ENTRY_BAD = 12'hFF7;

  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_SPC = 2'd0;
  localparam logic [1:0] REG_SB  = 2'd1;
  localparam logic [1:0] REG_FDS = 2'd2;

  localparam logic [7:0]  SPC_RESET = 8'd1;
  localparam logic [12:0] SB_RESET  = 13'd512;
  localparam logic [15:0] FDS_RESET = 16'd33;

  typedef enum logic [1:0] {
    ST_NEXT = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2,
    ST_LOAD = 2'd3
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

// ===== rtl/core/fcc_table.sv =====
// FAT table byte store: one write port, two registered read ports.
// Depends on fcc_pkg. Reads the byte pair at cluster + cluster/2, wrapped.
module fcc_table import fcc_pkg::*; #(
  parameter int TableBytes = FCC_TABLE_BYTES
) (
  input  logic        clk_i,
  input  tbl_ctl_t    ctl_i,
  input  logic [12:0] wr_index_i,
  input  logic [7:0]  wr_byte_i,
  input  logic [11:0] cluster_i,
  output logic [7:0]  lo_byte_o,
  output logic [7:0]  hi_byte_o
);

  localparam int AddrW = $clog2(TableBytes);

  logic [7:0] mem [TableBytes];

  logic [FCC_POS_W-1:0] wr_pos;
  logic [FCC_POS_W-1:0] off;
  logic [FCC_POS_W-1:0] lo_pos;
  logic [FCC_POS_W-1:0] hi_pos;
  logic                 wr_ok;
  logic [7:0]           lo_q;
  logic [7:0]           hi_q;

  // position is below 4*TableBytes, so two conditional subtracts suffice
  function automatic logic [FCC_POS_W-1:0] wrap_pos(input logic [FCC_POS_W-1:0] pos);
    logic [FCC_POS_W-1:0] p;
    p = pos;
    if (p >= FCC_POS_W'(2 * TableBytes)) begin
      p = p - FCC_POS_W'(2 * TableBytes);
    end
    if (p >= FCC_POS_W'(TableBytes)) begin
      p = p - FCC_POS_W'(TableBytes);
    end
    return p;
  endfunction

  assign wr_pos = FCC_POS_W'(wr_index_i);
  assign wr_ok  = wr_pos < FCC_POS_W'(TableBytes);
  assign off    = FCC_POS_W'(cluster_i) + FCC_POS_W'(cluster_i[11:1]);
  assign lo_pos = wrap_pos(off);
  assign hi_pos = wrap_pos(off + FCC_POS_W'(1));

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && wr_ok) begin
      mem[wr_pos[AddrW-1:0]] <= wr_byte_i;
    end
    if (ctl_i.rd_en) begin
      lo_q <= mem[lo_pos[AddrW-1:0]];
      hi_q <= mem[hi_pos[AddrW-1:0]];
    end
  end

  assign lo_byte_o = lo_q;
  assign hi_byte_o = hi_q;

endmodule

// ===== rtl/core/fat12_cluster_chain_step.sv =====
// FAT12 cluster chain step: table byte store, sector math, next-cluster unpack.
// Depends on fcc_pkg, fcc_table and fat12_cluster_chain_step_macros.svh.
//
//   channel   signals                                   handshake
//   request   req_type_i table_index_i table_byte_i     start_i & !busy_o
//             cluster_i bytes_left_i
//   result    sector_o read_bytes_o bytes_after_o       done_o, one cycle
//             next_cluster_o status_o
//   config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
// One word accepted per cycle; busy_o never rises. The input register loads at the
// accepting edge, then the table read register (also holding the multiply), then
// the result register; done_o is registered alongside the result register, so it
// rises together with the new result. Reset clears the pipeline valids and the
// config registers; the table contents stay undefined until written. The result
// side cannot stall.
`include "fat12_cluster_chain_step_macros.svh"

module fat12_cluster_chain_step import fcc_pkg::*; #(
  parameter int TableBytes = FCC_TABLE_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [12:0]           table_index_i,
  input  logic [7:0]            table_byte_i,
  input  logic [11:0]           cluster_i,
  input  logic [31:0]           bytes_left_i,
  output logic                  done_o,
  output logic [15:0]           sector_o,
  output logic [12:0]           read_bytes_o,
  output logic [31:0]           bytes_after_o,
  output logic [11:0]           next_cluster_o,
  output logic [1:0]            status_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0]  spc_q;
  logic [12:0] sb_q;
  logic [15:0] fds_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic        v1_q, v2_q, done_q;
  logic        req1_q, req2_q;
  logic [12:0] idx1_q;
  logic [7:0]  byte1_q;
  logic [11:0] clus1_q;
  logic [31:0] left1_q, left2_q;
  logic [15:0] prod2_q;
  logic [12:0] rd2_q;
  logic        odd2_q;

  logic [15:0] clus_m2;
  logic [15:0] prod_d;
  logic [12:0] rd_d;

  logic [7:0]  lo_byte, hi_byte;
  logic [15:0] pair;
  logic [11:0] next_d;
  logic [1:0]  status_d;
  logic [15:0] sector_d;
  logic [31:0] after_d;

  logic [15:0] sector_q;
  logic [12:0] read_bytes_q;
  logic [31:0] bytes_after_q;
  logic [11:0] next_cluster_q;
  logic [1:0]  status_q;

  tbl_ctl_t    tbl_ctl;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= SPC_RESET;
      sb_q  <= SB_RESET;
      fds_q <= FDS_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPC: spc_q <= pwdata[7:0];
        REG_SB:  sb_q  <= pwdata[12:0];
        REG_FDS: fds_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SPC: prdata = {24'd0, spc_q};
      REG_SB:  prdata = {19'd0, sb_q};
      REG_FDS: prdata = {16'd0, fds_q};
      default: prdata = 32'd0;
    endcase
  end

  assign busy_o = 1'b0;

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req1_q  <= req_type_i;
      idx1_q  <= table_index_i;
      byte1_q <= table_byte_i;
      clus1_q <= cluster_i;
      left1_q <= bytes_left_i;
    end
  end

  assign tbl_ctl.wr_en = v1_q && !req1_q;
  assign tbl_ctl.rd_en = v1_q && req1_q;

  fcc_table #(
    .TableBytes(TableBytes)
  ) u_table (
    .clk_i     (clk_i),
    .ctl_i     (tbl_ctl),
    .wr_index_i(idx1_q),
    .wr_byte_i (byte1_q),
    .cluster_i (clus1_q),
    .lo_byte_o (lo_byte),
    .hi_byte_o (hi_byte)
  );

  assign clus_m2 = {4'd0, clus1_q} - 16'd2;
  assign prod_d  = clus_m2 * {8'd0, spc_q};
  assign rd_d    = (left1_q < {19'd0, sb_q}) ? left1_q[12:0] : sb_q;

  // stage 2: multiply and min registered alongside the table read
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      req2_q  <= req1_q;
      prod2_q <= prod_d;
      rd2_q   <= rd_d;
      left2_q <= left1_q;
      odd2_q  <= clus1_q[0];
    end
  end

  assign pair     = {hi_byte, lo_byte};
  assign next_d   = odd2_q ? pair[15:4] : pair[11:0];
  assign sector_d = prod2_q + fds_q;
  assign after_d  = left2_q - {19'd0, rd2_q};

  always_comb begin
    if (next_d >= ENTRY_END) begin
      status_d = ST_END;
    end else if (next_d == ENTRY_BAD) begin
      status_d = ST_BAD;
    end else begin
      status_d = ST_NEXT;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (req2_q) begin
        sector_q       <= sector_d;
        read_bytes_q   <= rd2_q;
        bytes_after_q  <= after_d;
        next_cluster_q <= next_d;
        status_q       <= status_d;
      end else begin
        sector_q       <= 16'd0;
        read_bytes_q   <= 13'd0;
        bytes_after_q  <= 32'd0;
        next_cluster_q <= 12'd0;
        status_q       <= ST_LOAD;
      end
    end
  end

  assign done_o         = done_q;
  assign sector_o       = sector_q;
  assign read_bytes_o   = read_bytes_q;
  assign bytes_after_o  = bytes_after_q;
  assign next_cluster_o = next_cluster_q;
  assign status_o       = status_q;

  `FCC_ASSERT_NXT(a_accept_done, start_i && !busy_o, ##2 done_o)
  `FCC_ASSERT_IMP(a_done_from_pipe, done_o, $past(v2_q))
  `FCC_ASSERT_IMP(a_end_entry, done_o && status_o == ST_END, next_cluster_o >= ENTRY_END)
  `FCC_ASSERT_IMP(a_load_zero, done_o && status_o == ST_LOAD,
                  read_bytes_o == 13'd0 && bytes_after_o == 32'd0)

endmodule
